// ===== hdl/ohht_pkg.sv =====
package ohht_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam logic [15:0] NO_ID_DEF   = 16'd0;

    typedef enum logic [3:0] {
        OP_APPEND    = 4'd0,
        OP_HIT       = 4'd1,
        OP_BYID      = 4'd2,
        OP_BYMASK    = 4'd3,
        OP_ACTMASK   = 4'd4,
        OP_DEACTALL  = 4'd5,
        OP_DEACTMASK = 4'd6,
        OP_ACTONE    = 4'd7,
        OP_DEACTONE  = 4'd8,
        OP_RMONE     = 4'd9,
        OP_RMMASK    = 4'd10,
        OP_SETRECT   = 4'd11,
        OP_SETFLAGS  = 4'd12,
        OP_MOVETO    = 4'd13,
        OP_MOVEBY    = 4'd14,
        OP_CENTER    = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        CL_APPEND,
        CL_SEARCH,
        CL_BULK,
        CL_REMOVE
    } t_cls;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_RESP
    } t_state;

    typedef struct packed {
        t_op         op;
        t_cls        cls;
        logic [15:0] id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] r;
        logic [15:0] b;
        logic [31:0] fv;
        logic [31:0] fm;
    } t_item;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [31:0] flags;
        logic        active;
    } t_entry;

    function automatic t_cls classify(t_op op);
        t_cls c;
        unique case (op)
            OP_APPEND:                            c = CL_APPEND;
            OP_ACTMASK, OP_DEACTALL, OP_DEACTMASK: c = CL_BULK;
            OP_RMONE, OP_RMMASK:                  c = CL_REMOVE;
            default:                              c = CL_SEARCH;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/ordered_hotspot_hit_table_unit.sv =====
// Flow: append goes from idle through apply to the response state; a full table or clear-all
//   goes straight to response; scanning commands read up to the n live entries, then may apply.
// The back end takes one command at a time, its scan reading one entry per cycle from the
//   entry memory; a two-deep queue takes new items early.
// Reset: synchronous, active low; empties the table and the queue. Results
//   appear for one cycle on o_valid and cannot be stalled.
module ordered_hotspot_hit_table_unit #(
    parameter int unsigned ENTRIES = ohht_pkg::ENTRIES_DEF,
    parameter logic [15:0] NO_ID   = ohht_pkg::NO_ID_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_cmd,
    input  logic [15:0] i_spot_id,
    input  logic [15:0] i_left_or_x,
    input  logic [15:0] i_top_or_y,
    input  logic [15:0] i_right_edge,
    input  logic [15:0] i_bottom_edge,
    input  logic [31:0] i_flag_value,
    input  logic [31:0] i_flag_mask,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_hit_id,
    output logic [15:0] o_hit_left,
    output logic [15:0] o_hit_top,
    output logic [15:0] o_hit_right,
    output logic [15:0] o_hit_bottom,
    output logic [31:0] o_hit_flags,
    output logic        o_hit_active,
    output logic [15:0] o_center_x,
    output logic [15:0] o_center_y,
    output logic [4:0]  o_live_count
);

    ohht_pkg::t_item in_item, q_item;
    logic            q_valid, q_pop;

    // Pack the command; the front stage tags it with its class.
    always_comb begin
        in_item     = '0;
        in_item.op  = ohht_pkg::t_op'(i_cmd);
        in_item.cls = ohht_pkg::CL_SEARCH;
        in_item.id  = i_spot_id;
        in_item.x   = i_left_or_x;
        in_item.y   = i_top_or_y;
        in_item.r   = i_right_edge;
        in_item.b   = i_bottom_edge;
        in_item.fv  = i_flag_value;
        in_item.fm  = i_flag_mask;
    end

    // Front: accept and queue commands.
    ohht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_item  (in_item),
        .i_pop   (q_pop),
        .o_full  (busy),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: scan, update and compact the entry table, then report.
    ohht_back #(
        .ENTRIES (ENTRIES),
        .NO_ID   (NO_ID)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_hit_id     (o_hit_id),
        .o_hit_left   (o_hit_left),
        .o_hit_top    (o_hit_top),
        .o_hit_right  (o_hit_right),
        .o_hit_bottom (o_hit_bottom),
        .o_hit_flags  (o_hit_flags),
        .o_hit_active (o_hit_active),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_live_count (o_live_count)
    );

endmodule

// ===== hdl/ohht_front.sv =====
module ohht_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ohht_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output ohht_pkg::t_item o_item
);

    ohht_pkg::t_item r_q [2];
    ohht_pkg::t_item push_item;
    logic            r_wp, r_rp;
    logic [1:0]      r_qcnt;
    logic            push_ok, pop_ok;

    assign o_full  = (r_qcnt == 2'd2);
    assign o_valid = (r_qcnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // tag the item with its class on the way in
    always_comb begin
        push_item     = i_item;
        push_item.cls = ohht_pkg::classify(i_item.op);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_qcnt <= r_qcnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

// ===== hdl/ohht_back.sv =====
module ohht_back #(
    parameter int unsigned ENTRIES = ohht_pkg::ENTRIES_DEF,
    parameter logic [15:0] NO_ID   = ohht_pkg::NO_ID_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ohht_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [15:0]     o_hit_id,
    output logic [15:0]     o_hit_left,
    output logic [15:0]     o_hit_top,
    output logic [15:0]     o_hit_right,
    output logic [15:0]     o_hit_bottom,
    output logic [31:0]     o_hit_flags,
    output logic            o_hit_active,
    output logic [15:0]     o_center_x,
    output logic [15:0]     o_center_y,
    output logic [4:0]      o_live_count
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    ohht_pkg::t_entry  r_mem [ENTRIES];
    ohht_pkg::t_entry  r_rd;
    ohht_pkg::t_state  r_state, n_state;
    ohht_pkg::t_item   r_cmd, n_cmd;
    ohht_pkg::t_entry  r_ent, n_ent, upd, bulk_ent;
    ohht_pkg::t_status r_status, n_status;
    logic [CW-1:0]     r_cnt, n_cnt, r_ridx, n_ridx, r_widx, n_widx;
    logic [AW-1:0]     r_eidx, n_eidx, r_midx, n_midx;
    logic              r_rvalid, n_rvalid, r_found, n_found;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    ohht_pkg::t_entry  mem_wd;
    logic              full, scan_done, hit_m, id_m, all_m, any_m, sel_m, search_hit, drop;
    logic              read_only;

    assign full      = (r_cnt >= CW'(ENTRIES));
    assign scan_done = !r_rvalid && (r_ridx >= r_cnt);
    assign id_m      = (r_rd.id == r_cmd.id);
    assign all_m     = ((r_rd.flags & r_cmd.fm) == r_cmd.fm);
    assign any_m     = ((r_rd.flags & r_cmd.fm) != 32'd0);
    assign hit_m     = r_rd.active
                       && ($signed(r_rd.left) <= $signed(r_cmd.x))
                       && ($signed(r_cmd.x) < $signed(r_rd.right))
                       && ($signed(r_rd.top) <= $signed(r_cmd.y))
                       && ($signed(r_cmd.y) < $signed(r_rd.bottom));
    assign sel_m     = (r_cmd.op == ohht_pkg::OP_HIT)    ? hit_m :
                       (r_cmd.op == ohht_pkg::OP_BYMASK) ? all_m : id_m;
    assign search_hit = r_rvalid && (r_cmd.cls == ohht_pkg::CL_SEARCH) && sel_m;
    assign drop      = (r_cmd.op == ohht_pkg::OP_RMONE) ? (id_m && !r_found) : any_m;
    assign read_only = (r_cmd.op == ohht_pkg::OP_HIT) || (r_cmd.op == ohht_pkg::OP_BYID)
                       || (r_cmd.op == ohht_pkg::OP_BYMASK) || (r_cmd.op == ohht_pkg::OP_CENTER);
    assign o_pop     = (r_state == ohht_pkg::S_IDLE) && i_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ohht_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_item.cls == ohht_pkg::CL_APPEND)
                        n_state = full ? ohht_pkg::S_RESP : ohht_pkg::S_APPLY;
                    else if (i_item.op == ohht_pkg::OP_RMMASK && i_item.fm == 32'd0)
                        n_state = ohht_pkg::S_RESP;
                    else
                        n_state = ohht_pkg::S_SCAN;
                end
            end
            ohht_pkg::S_SCAN: begin
                if (search_hit)
                    n_state = read_only ? ohht_pkg::S_RESP : ohht_pkg::S_APPLY;
                else if (scan_done)
                    n_state = ohht_pkg::S_RESP;
            end
            ohht_pkg::S_APPLY: n_state = ohht_pkg::S_RESP;
            ohht_pkg::S_RESP:  n_state = ohht_pkg::S_IDLE;
            default:           n_state = ohht_pkg::S_IDLE;
        endcase
    end

    // entry update for id-addressed writes
    always_comb begin
        upd = r_ent;
        unique case (r_cmd.op)
            ohht_pkg::OP_ACTONE:   upd.active = 1'b1;
            ohht_pkg::OP_DEACTONE: upd.active = 1'b0;
            ohht_pkg::OP_SETRECT: begin
                upd.left   = r_cmd.x;
                upd.top    = r_cmd.y;
                upd.right  = r_cmd.r;
                upd.bottom = r_cmd.b;
            end
            ohht_pkg::OP_SETFLAGS: upd.flags = (r_ent.flags & ~r_cmd.fm) | r_cmd.fv;
            ohht_pkg::OP_MOVETO: begin
                upd.left   = r_cmd.x;
                upd.top    = r_cmd.y;
                upd.right  = r_cmd.x + (r_ent.right - r_ent.left);
                upd.bottom = r_cmd.y + (r_ent.bottom - r_ent.top);
            end
            ohht_pkg::OP_MOVEBY: begin
                upd.left   = r_ent.left + r_cmd.x;
                upd.top    = r_ent.top + r_cmd.y;
                upd.right  = r_ent.right + r_cmd.x;
                upd.bottom = r_ent.bottom + r_cmd.y;
            end
            default: upd = r_ent;
        endcase
    end

    always_comb begin
        bulk_ent = r_rd;
        unique case (r_cmd.op)
            ohht_pkg::OP_ACTMASK:   if (r_cmd.fm == 32'd0 || any_m) bulk_ent.active = 1'b1;
            ohht_pkg::OP_DEACTALL:  bulk_ent.active = 1'b0;
            ohht_pkg::OP_DEACTMASK: if (any_m) bulk_ent.active = 1'b0;
            default:                bulk_ent = r_rd;
        endcase
    end

    // datapath
    always_comb begin
        n_cmd    = r_cmd;
        n_ent    = r_ent;
        n_status = r_status;
        n_cnt    = r_cnt;
        n_ridx   = r_ridx;
        n_widx   = r_widx;
        n_eidx   = r_eidx;
        n_midx   = r_midx;
        n_rvalid = r_rvalid;
        n_found  = r_found;
        mem_we   = 1'b0;
        mem_wa   = r_eidx;
        mem_wd   = bulk_ent;
        unique case (r_state)
            ohht_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_item;
                    n_ridx   = '0;
                    n_widx   = '0;
                    n_rvalid = 1'b0;
                    n_found  = 1'b0;
                    n_status = ohht_pkg::ST_OK;
                    if (i_item.cls == ohht_pkg::CL_APPEND) begin
                        if (full) begin
                            n_status = ohht_pkg::ST_FULL;
                        end else begin
                            n_found = 1'b1;
                            n_midx  = AW'(r_cnt);
                            n_ent   = '{id: i_item.id, left: i_item.x, top: i_item.y,
                                        right: i_item.r, bottom: i_item.b,
                                        flags: i_item.fv, active: 1'b0};
                        end
                    end else if (i_item.op == ohht_pkg::OP_RMMASK && i_item.fm == 32'd0) begin
                        n_cnt = '0;
                    end
                end
            end
            ohht_pkg::S_SCAN: begin
                // issue the next read while judging the previous one
                if (r_ridx < r_cnt) begin
                    n_rvalid = 1'b1;
                    n_eidx   = AW'(r_ridx);
                    n_ridx   = r_ridx + 1'b1;
                end else begin
                    n_rvalid = 1'b0;
                end
                if (r_rvalid) begin
                    unique case (r_cmd.cls)
                        ohht_pkg::CL_SEARCH: begin
                            if (sel_m) begin
                                n_found = 1'b1;
                                n_ent   = r_rd;
                                n_midx  = r_eidx;
                            end
                        end
                        ohht_pkg::CL_BULK: begin
                            mem_we = 1'b1;
                        end
                        ohht_pkg::CL_REMOVE: begin
                            if (drop) begin
                                if (r_cmd.op == ohht_pkg::OP_RMONE) begin
                                    n_found = 1'b1;
                                    n_ent   = r_rd;
                                end
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = AW'(r_widx);
                                mem_wd = r_rd;
                                n_widx = r_widx + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (scan_done) begin
                    if (r_cmd.cls == ohht_pkg::CL_SEARCH)
                        n_status = ohht_pkg::ST_NOMATCH;
                    if (r_cmd.cls == ohht_pkg::CL_REMOVE) begin
                        n_cnt = r_widx;
                        if (r_cmd.op == ohht_pkg::OP_RMONE && !r_found)
                            n_status = ohht_pkg::ST_NOMATCH;
                    end
                end
            end
            ohht_pkg::S_APPLY: begin
                mem_we = 1'b1;
                mem_wa = r_midx;
                mem_wd = upd;
                n_ent  = upd;
                if (r_cmd.cls == ohht_pkg::CL_APPEND) n_cnt = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[AW'(r_ridx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ohht_pkg::S_IDLE;
            r_cnt    <= '0;
            r_rvalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rvalid <= n_rvalid;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ent    <= n_ent;
        r_status <= n_status;
        r_ridx   <= n_ridx;
        r_widx   <= n_widx;
        r_eidx   <= n_eidx;
        r_midx   <= n_midx;
    end

    // result register
    logic signed [16:0] sum_x, sum_y, half_x, half_y;
    logic               r_valid;
    logic [1:0]         r_o_status;
    ohht_pkg::t_entry   r_o_ent;
    logic [15:0]        r_o_cx, r_o_cy;
    logic [4:0]         r_o_live;

    assign sum_x  = $signed({r_ent.left[15], r_ent.left}) + $signed({r_ent.right[15], r_ent.right});
    assign sum_y  = $signed({r_ent.top[15], r_ent.top}) + $signed({r_ent.bottom[15], r_ent.bottom});
    assign half_x = (sum_x + {16'd0, sum_x[16]}) >>> 1;
    assign half_y = (sum_y + {16'd0, sum_y[16]}) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ohht_pkg::S_RESP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ohht_pkg::S_RESP) begin
            r_o_status <= r_status;
            r_o_live   <= 5'(r_cnt);
            if (r_found) begin
                r_o_ent <= r_ent;
                r_o_cx  <= half_x[15:0];
                r_o_cy  <= half_y[15:0];
            end else begin
                r_o_ent <= '{id: NO_ID, default: '0};
                r_o_cx  <= 16'd0;
                r_o_cy  <= 16'd0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_o_status;
    assign o_hit_id     = r_o_ent.id;
    assign o_hit_left   = r_o_ent.left;
    assign o_hit_top    = r_o_ent.top;
    assign o_hit_right  = r_o_ent.right;
    assign o_hit_bottom = r_o_ent.bottom;
    assign o_hit_flags  = r_o_ent.flags;
    assign o_hit_active = r_o_ent.active;
    assign o_center_x   = r_o_cx;
    assign o_center_y   = r_o_cy;
    assign o_live_count = r_o_live;

endmodule
